// ----- sv/clt_pkg.sv -----
// Shared types and constants for the configuration line tokenizer.
// Depends on nothing; every other source file uses it.
`default_nettype none

package clt_pkg;

  // Field widths
  localparam int unsigned CharInW  = 8;
  localparam int unsigned CharOutW = 7;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CountW   = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Up to three results per input transfer (end of word, '=', end of word)
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned ResCntW = 2;

  localparam int unsigned QueueDepthDefault = 4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxWords = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLen   = 1'b1;

  localparam logic [CountW-1:0] MaxWordsRst = 8'd32;
  localparam logic [LenW-1:0]   MaxLenRst   = 16'd512;

  // Character codes
  localparam logic [CharInW-1:0] ChTab       = 8'h09;
  localparam logic [CharInW-1:0] ChNewline   = 8'h0a;
  localparam logic [CharInW-1:0] ChCr        = 8'h0d;
  localparam logic [CharInW-1:0] ChSpace     = 8'h20;
  localparam logic [CharInW-1:0] ChQuote     = 8'h22;
  localparam logic [CharInW-1:0] ChHash      = 8'h23;
  localparam logic [CharInW-1:0] ChEquals    = 8'h3d;
  localparam logic [CharInW-1:0] ChBackslash = 8'h5c;
  localparam logic [CharInW-1:0] ChPrintLo   = 8'h20;
  localparam logic [CharInW-1:0] ChPrintHi   = 8'h7f;

  typedef enum logic [KindW-1:0] {
    KindChar = 2'd0,
    KindEow  = 2'd1,
    KindEol  = 2'd2,
    KindErr  = 2'd3
  } clt_kind_e;

  typedef struct packed {
    clt_kind_e             kind;
    logic [CharOutW-1:0]   char_out;
    logic [CountW-1:0]     word_index;
  } clt_res_t;

  // All results caused by one input transfer
  typedef struct packed {
    logic [ResCntW-1:0]      cnt;
    clt_res_t [MaxRes-1:0]   res;
  } clt_bundle_t;

  typedef struct packed {
    logic        valid;
    clt_bundle_t data;
  } clt_push_t;

endpackage

`default_nettype wire

// ----- sv/clt_if.sv -----
// Valid/ready channel interfaces for the tokenizer input and result streams.
// Depends on clt_pkg for field widths.
`default_nettype none

interface clt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [clt_pkg::CharInW-1:0]  char_in;

  modport source (output valid, output command, output char_in, input ready);
  modport sink   (input valid, input command, input char_in, output ready);
endinterface

interface clt_out_if;
  logic                          valid;
  logic                          ready;
  logic [clt_pkg::KindW-1:0]     kind;
  logic [clt_pkg::CharOutW-1:0]  char_out;
  logic [clt_pkg::CountW-1:0]    word_index;
  logic                          last;

  modport source (output valid, output kind, output char_out, output word_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input char_out, input word_index,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- sv/config_line_tokenizer.sv -----
// Top level of the configuration line tokenizer: front end, bundle queue, back end.
// Depends on clt_pkg, clt_if, clt_front, clt_queue and clt_back.
`default_nettype none

// Shell-style word splitter for configuration text. One byte (or an
// end-of-input command) is taken per transfer on in_i, and a new transfer is
// taken every cycle while the result queue has room. Each transfer yields zero
// to three results (word character, end of word, end of line, parse error),
// all of them computed in the cycle the byte is taken and stored as one
// bundle in a QueueDepth-entry queue. The back end sends one result per
// cycle on out_o while out_o.ready is high, so the sustained rate is one input
// byte per cycle while bytes yield at most one result each; the queue absorbs
// the bursts of bytes that yield more. A result passes through the queue and
// then the output register before it shows on out_o. Bytes that yield no result
// (whitespace, comment text, dropped characters) never enter the queue. A zero
// limit means unlimited; the user must write the two limit registers through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle; this is not enforced.
module config_line_tokenizer #(
  parameter int unsigned QueueDepth = clt_pkg::QueueDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [clt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [clt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  clt_in_if.sink                             in_i,
  clt_out_if.source                          out_o
);
  import clt_pkg::*;

  clt_push_t    push;
  logic         push_ready;
  logic         pop_valid;
  clt_bundle_t  pop_data;
  logic         pop;

  // Parse state machine; emits one bundle per transfer that yields results
  clt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // Decouples the parser from output backpressure
  clt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  // Serializes each bundle, marking its final result with last
  clt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // The queue head only goes away when the back end takes its final result
  a_pop_before_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pop_valid) |-> $past(pop))
    else $error("queue emptied without a pop");

  // Results of one bundle leave back to back
  a_bundle_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> out_o.valid)
    else $error("gap inside a result bundle");

  // Only printable characters are ever sent as word characters
  a_char_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KindChar)) |-> (out_o.char_out >= 7'h20))
    else $error("unprintable character sent");

  // Markers carry no character
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind != KindChar)) |-> (out_o.char_out == '0))
    else $error("marker with nonzero character");
`endif

endmodule

`default_nettype wire

// ----- sv/clt_front.sv -----
// Tokenizer front end: config registers, parse state machine and result bundling.
// Depends on clt_pkg and clt_in_if.
`default_nettype none

module clt_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [clt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [clt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  clt_in_if.sink                             in_i,
  output clt_pkg::clt_push_t                 push_o,
  input  wire logic                          push_ready_i
);
  import clt_pkg::*;

  localparam logic [2:0] StStart = 3'd0;
  localparam logic [2:0] StSkip  = 3'd1;
  localparam logic [2:0] StQuote = 3'd2;
  localparam logic [2:0] StQLit  = 3'd3;
  localparam logic [2:0] StWord  = 3'd4;
  localparam logic [2:0] StWLit  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;
  localparam logic [2:0] StError = 3'd7;

  logic [CountW-1:0]  max_words_q;
  logic [LenW-1:0]    max_len_q;
  logic [2:0]         st_q, st_d, st0;
  logic [CountW-1:0]  wc_q, wc_d, wc0, wc1, wc2;
  logic [LenW-1:0]    wl_q, wl_d, wl1, wl2;
  logic               accept, line_over;
  logic               eow1, chr, eow2, eol, err;
  logic               kept0, kept1, chr_ok;
  logic               e1, e2, e3, e4;
  logic               is_nl, is_hash, is_quote, is_bs, is_eq, is_space, printable;
  logic [CharInW-1:0] c;
  logic [ResCntW-1:0] n;
  clt_bundle_t        bundle;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;

  assign c         = in_i.char_in;
  assign is_nl     = (c == ChNewline);
  assign is_hash   = (c == ChHash);
  assign is_quote  = (c == ChQuote);
  assign is_bs     = (c == ChBackslash);
  assign is_eq     = (c == ChEquals);
  assign is_space  = c inside {ChSpace, [ChTab:ChCr]};
  assign printable = c inside {[ChPrintLo:ChPrintHi]};
  assign line_over = (st_q == StDone) || (st_q == StError);

  // Per-step actions, in the order they occur: eow1, chr, eow2, eol/err
  always_comb begin
    st0  = st_q;
    wc0  = wc_q;
    st_d = st_q;
    eow1 = 1'b0;
    chr  = 1'b0;
    eow2 = 1'b0;
    eol  = 1'b0;
    err  = 1'b0;
    if (in_i.command) begin
      if (!line_over) begin
        eow1 = (wl_q != '0);
        eol  = 1'b1;
        st_d = StDone;
      end
    end else begin
      if (line_over) begin
        st0 = StStart;
        wc0 = '0;
      end
      st_d = st0;
      case (st0)
        StStart: begin
          if (is_nl) begin
            eol  = 1'b1;
            st_d = StDone;
          end else if (is_hash) begin
            st_d = StSkip;
          end else if (is_space) begin
            st_d = StStart;
          end else if (is_bs) begin
            st_d = StWLit;
          end else if (is_quote) begin
            st_d = StQuote;
          end else begin
            chr  = 1'b1;
            eow2 = is_eq;
            st_d = is_eq ? StStart : StWord;
          end
        end
        StSkip: begin
          if (is_nl) begin
            eol  = 1'b1;
            st_d = StDone;
          end
        end
        StQuote: begin
          if (is_hash) begin
            eow1 = 1'b1;
            err  = 1'b1;
            st_d = StError;
          end else if (is_quote) begin
            eow1 = 1'b1;
            st_d = StStart;
          end else if (is_bs) begin
            st_d = StQLit;
          end else begin
            chr = 1'b1;
          end
        end
        StQLit: begin
          chr  = !is_nl;
          st_d = StQuote;
        end
        StWord: begin
          if (is_hash) begin
            eow1 = 1'b1;
            st_d = StSkip;
          end else if (is_nl) begin
            eow1 = 1'b1;
            eol  = 1'b1;
            st_d = StDone;
          end else if (is_space) begin
            eow1 = 1'b1;
            st_d = StStart;
          end else if (is_eq) begin
            // close the word, then '=' stands as a word of its own
            eow1 = 1'b1;
            chr  = 1'b1;
            eow2 = 1'b1;
            st_d = StStart;
          end else if (is_bs) begin
            st_d = StWLit;
          end else begin
            chr = 1'b1;
          end
        end
        StWLit: begin
          chr  = !is_nl;
          st_d = StWord;
        end
        default: begin
          st_d = st0;
        end
      endcase
    end
  end

  // Word count and length bookkeeping
  assign kept0  = (max_words_q == '0) || (wc0 < max_words_q);
  assign wc1    = (eow1 && kept0 && (wc0 != '1)) ? wc0 + 8'd1 : wc0;
  assign wl1    = eow1 ? '0 : wl_q;
  assign chr_ok = chr && printable && !((max_len_q != '0) && (wl1 >= max_len_q));
  assign wl2    = (chr_ok && (wl1 != '1)) ? wl1 + 16'd1 : wl1;
  assign kept1  = (max_words_q == '0) || (wc1 < max_words_q);
  assign wc2    = (eow2 && kept1 && (wc1 != '1)) ? wc1 + 8'd1 : wc1;
  assign wc_d   = wc2;
  assign wl_d   = eow2 ? '0 : wl2;

  assign e1 = eow1 && kept0;
  assign e2 = chr_ok && kept1;
  assign e3 = eow2 && kept1;
  assign e4 = eol || err;

  always_comb begin
    bundle = '0;
    n      = '0;
    if (e1) begin
      bundle.res[n].kind       = KindEow;
      bundle.res[n].word_index = wc0;
      n = n + 2'd1;
    end
    if (e2) begin
      bundle.res[n].kind       = KindChar;
      bundle.res[n].char_out   = c[CharOutW-1:0];
      bundle.res[n].word_index = wc1;
      n = n + 2'd1;
    end
    if (e3) begin
      bundle.res[n].kind       = KindEow;
      bundle.res[n].word_index = wc1;
      n = n + 2'd1;
    end
    if (e4) begin
      bundle.res[n].kind       = err ? KindErr : KindEol;
      bundle.res[n].word_index = wc2;
      n = n + 2'd1;
    end
    bundle.cnt = n;
  end

  assign push_o.valid = accept && (bundle.cnt != '0);
  assign push_o.data  = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_words_q <= MaxWordsRst;
      max_len_q   <= MaxLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxWords: max_words_q <= cfg_wdata_i[CountW-1:0];
        CfgMaxLen:   max_len_q   <= cfg_wdata_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StStart;
      wc_q <= '0;
      wl_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
      wc_q <= wc_d;
      wl_q <= wl_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/clt_queue.sv -----
// Small FIFO of result bundles between the tokenizer front and back ends.
// Depends on clt_pkg for the bundle type.
`default_nettype none

module clt_queue #(
  parameter int unsigned Depth = clt_pkg::QueueDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire clt_pkg::clt_push_t    push_i,
  output logic                       push_ready_o,
  output logic                       pop_valid_o,
  output clt_pkg::clt_bundle_t       pop_data_o,
  input  wire logic                  pop_i
);
  import clt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  clt_bundle_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/clt_back.sv -----
// Tokenizer back end: registers a bundle on out_o one result per unstalled cycle.
// Depends on clt_pkg and clt_out_if.
`default_nettype none

module clt_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pop_valid_i,
  input  wire clt_pkg::clt_bundle_t  pop_data_i,
  output logic                       pop_o,
  clt_out_if.source                  out_o
);
  import clt_pkg::*;

  logic [ResCntW-1:0]  slot_q;
  logic                valid_q;
  clt_res_t            res_q;
  logic                last_q;
  logic                load, slot_last;

  assign load      = pop_valid_i && (!valid_q || out_o.ready);
  assign slot_last = (slot_q == (pop_data_i.cnt - 2'd1));
  assign pop_o     = load && slot_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        slot_q  <= slot_last ? '0 : slot_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= pop_data_i.res[slot_q];
      last_q <= slot_last;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.kind       = res_q.kind;
  assign out_o.char_out   = res_q.char_out;
  assign out_o.word_index = res_q.word_index;
  assign out_o.last       = last_q;

endmodule

`default_nettype wire

// ----- bench/config_line_tokenizer_tb.sv -----
// Self-checking testbench for config_line_tokenizer: a directed table, then random lines.
// Results are predicted by an in-bench copy of the tokenizer and compared in order.
// Depends on clt_pkg, clt_if and the config_line_tokenizer RTL.
`default_nettype none

module config_line_tokenizer_tb;
  import clt_pkg::*;

  localparam int unsigned IdleLimit = 2000;  // cycles without any transfer
  localparam int unsigned DrainWait = 6;     // extra wait after the expected results have drained

  localparam logic CmdChar = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // Parser states of the predictor
  typedef enum logic [2:0] {
    PsStart    = 3'd0,
    PsComment  = 3'd1,
    PsQuote    = 3'd2,
    PsQuoteLit = 3'd3,
    PsWord     = 3'd4,
    PsWordLit  = 3'd5,
    PsLineDone = 3'd6,
    PsError    = 3'd7
  } parse_e;

  typedef struct packed {
    clt_kind_e           kind;
    logic [CharOutW-1:0] char_out;
    logic [CountW-1:0]   word_index;
    logic                last;
  } token_t;

  typedef struct packed {
    logic               cmd;
    logic [CharInW-1:0] ch;
  } byte_in_t;

  // Directed row: typed = 1 means the count and the final result are checked
  // against the row as well as against the predictor.
  typedef struct packed {
    logic               cmd;
    logic [CharInW-1:0] ch;
    logic               typed;
    logic [1:0]         n;
    clt_kind_e          kind;
    logic [CountW-1:0]  idx;
  } dir_row_t;

  localparam int unsigned DirRows = 27;
  localparam dir_row_t DirTab [DirRows] = '{
    '{CmdEnd,  8'h00,       1'b1, 2'd1, KindEol,  8'd0},  // end of input right after reset
    '{CmdChar, "a",         1'b1, 2'd1, KindChar, 8'd0},  // restarts the ended line
    '{CmdChar, ChEquals,    1'b1, 2'd3, KindEow,  8'd1},  // '=' inside a word: three results
    '{CmdChar, 8'hff,       1'b1, 2'd0, KindChar, 8'd0},  // unprintable opens an empty word
    '{CmdChar, ChPrintHi,   1'b1, 2'd1, KindChar, 8'd2},
    '{CmdChar, ChBackslash, 1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChNewline,   1'b0, 2'd0, KindChar, 8'd0},  // escaped newline joins lines
    '{CmdChar, ChQuote,     1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChTab,       1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChQuote,     1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChSpace,     1'b0, 2'd0, KindChar, 8'd0},  // space kept inside quotes
    '{CmdChar, ChBackslash, 1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChQuote,     1'b0, 2'd0, KindChar, 8'd0},  // escaped quote
    '{CmdChar, 8'h00,       1'b1, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChHash,      1'b1, 2'd2, KindErr,  8'd4},  // hash in quotes
    '{CmdChar, ChHash,      1'b0, 2'd0, KindChar, 8'd0},  // comment after the error
    '{CmdChar, "x",         1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChNewline,   1'b1, 2'd1, KindEol,  8'd0},
    '{CmdEnd,  8'h00,       1'b1, 2'd0, KindChar, 8'd0},  // end of input on an ended line
    '{CmdChar, "b",         1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, 8'h80,       1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChHash,      1'b0, 2'd0, KindChar, 8'd0},
    '{CmdEnd,  8'h00,       1'b1, 2'd1, KindEol,  8'd1},
    '{CmdChar, ChQuote,     1'b0, 2'd0, KindChar, 8'd0},
    '{CmdEnd,  8'h00,       1'b1, 2'd1, KindEol,  8'd0},  // empty open quote is not closed
    '{CmdChar, "d",         1'b0, 2'd0, KindChar, 8'd0},
    '{CmdChar, ChNewline,   1'b1, 2'd2, KindEol,  8'd1}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  clt_in_if  in_ch ();
  clt_out_if out_ch ();

  config_line_tokenizer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: parser, counters and the two limit registers
  // ---------------------------------------------------------------------
  parse_e            ps;
  logic [CountW-1:0] wcnt;
  logic [LenW-1:0]   wlen;
  logic [CountW-1:0] lim_words;
  logic [LenW-1:0]   lim_len;

  token_t   step_buf[$];   // results of the byte being predicted
  token_t   token_q[$];    // expected results, oldest first
  byte_in_t line_q[$];     // bytes of the next random line
  int       err_cnt;
  int       src_calm;
  int       snk_calm;
  int       quiet_cycles;

  task automatic note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic void emit(clt_kind_e k, logic [CharOutW-1:0] c);
    token_t r;
    if (step_buf.size() >= MaxRes) return;
    r.kind       = k;
    r.char_out   = c;
    r.word_index = wcnt;
    r.last       = 1'b0;
    step_buf.push_back(r);
  endfunction

  function automatic logic word_kept();
    return (lim_words == '0) || (wcnt < lim_words);
  endfunction

  function automatic logic is_ws(logic [CharInW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void keep_char(logic [CharInW-1:0] c);
    if (c < ChPrintLo || c > ChPrintHi) return;
    if (lim_len != '0 && wlen >= lim_len) return;
    if (wlen != '1) wlen++;
    if (word_kept()) emit(KindChar, c[CharOutW-1:0]);
  endfunction

  function automatic void close_word();
    if (word_kept()) begin
      emit(KindEow, '0);
      if (wcnt != '1) wcnt++;
    end
    wlen = '0;
  endfunction

  // Byte seen while looking for the start of a word
  function automatic parse_e word_begin(logic [CharInW-1:0] c);
    if (c == ChNewline) begin
      emit(KindEol, '0);
      return PsLineDone;
    end
    if (c == ChHash) return PsComment;
    if (is_ws(c)) return PsStart;
    if (c == ChBackslash) return PsWordLit;
    if (c == ChQuote) return PsQuote;
    keep_char(c);
    if (c == ChEquals) begin
      close_word();
      return PsStart;
    end
    return PsWord;
  endfunction

  function automatic parse_e advance(logic [CharInW-1:0] c);
    case (ps)
      PsStart: begin
        return word_begin(c);
      end
      PsComment: begin
        if (c == ChNewline) begin
          emit(KindEol, '0);
          return PsLineDone;
        end
        return PsComment;
      end
      PsQuote: begin
        if (c == ChHash) begin
          close_word();
          emit(KindErr, '0);
          return PsError;
        end
        if (c == ChQuote) begin
          close_word();
          return PsStart;
        end
        if (c == ChBackslash) return PsQuoteLit;
        keep_char(c);
        return PsQuote;
      end
      PsQuoteLit: begin
        if (c != ChNewline) keep_char(c);
        return PsQuote;
      end
      PsWord: begin
        if (c == ChHash) begin
          close_word();
          return PsComment;
        end
        if (c == ChNewline) begin
          close_word();
          emit(KindEol, '0);
          return PsLineDone;
        end
        if (is_ws(c)) begin
          close_word();
          return PsStart;
        end
        if (c == ChEquals) begin
          // word ends, then '=' stands as a word of its own
          close_word();
          void'(word_begin(c));
          return PsStart;
        end
        if (c == ChBackslash) return PsWordLit;
        keep_char(c);
        return PsWord;
      end
      PsWordLit: begin
        if (c != ChNewline) keep_char(c);
        return PsWord;
      end
      default: begin
        return ps;
      end
    endcase
  endfunction

  // Predicts one accepted byte or end-of-input; queues its results.
  function automatic int tokenize_step(logic cmd, logic [CharInW-1:0] c);
    token_t r;
    step_buf.delete();
    if (cmd == CmdEnd) begin
      if (ps != PsLineDone && ps != PsError) begin
        if (wlen != '0) close_word();
        emit(KindEol, '0);
        ps = PsLineDone;
      end
    end else begin
      // a new byte after an ended or failed line starts a fresh line
      if (ps == PsLineDone || ps == PsError) begin
        wcnt = '0;
        ps   = PsStart;
      end
      ps = advance(c);
    end
    foreach (step_buf[i]) begin
      r      = step_buf[i];
      r.last = (i == step_buf.size() - 1);
      step_buf[i] = r;
      token_q.push_back(r);
    end
    return step_buf.size();
  endfunction

  // Random idle gaps between transfers, with occasional stretches of back-to-back traffic
  function automatic int unsigned pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------
  // Input side: one transfer per call, predicted at the accepting edge
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic cmd, input logic [CharInW-1:0] c, output int n);
    int unsigned gap;
    gap = pick_gap(src_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.char_in <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = tokenize_step(cmd, c);
  endtask

  // Block goes quiet: input stopped, every expected result drained, then a
  // DrainWait wait for anything still in flight.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgMaxWords) lim_words = data[CountW-1:0];
    else lim_len = data[LenW-1:0];
  endtask

  // ---------------------------------------------------------------------
  // Random line builder: mostly well-formed words, some noise
  // ---------------------------------------------------------------------
  function automatic void put_byte(logic [CharInW-1:0] c);
    byte_in_t b;
    b.cmd = CmdChar;
    b.ch  = c;
    line_q.push_back(b);
  endfunction

  function automatic void put_end();
    byte_in_t b;
    b.cmd = CmdEnd;
    b.ch  = CharInW'($urandom_range(0, 255));
    line_q.push_back(b);
  endfunction

  function automatic logic [CharInW-1:0] plain_char();
    logic [CharInW-1:0] c;
    do begin
      c = CharInW'($urandom_range(8'h21, 8'h7e));
    end while (c == ChHash || c == ChQuote || c == ChBackslash || c == ChEquals);
    return c;
  endfunction

  function automatic logic [CharInW-1:0] quoted_char();
    logic [CharInW-1:0] c;
    do begin
      c = CharInW'($urandom_range(ChPrintLo, ChPrintHi));
    end while (c == ChHash || c == ChQuote || c == ChBackslash);
    return c;
  endfunction

  function automatic logic [CharInW-1:0] blank_char();
    case ($urandom_range(0, 4))
      0: return ChTab;
      1: return 8'h0b;
      2: return 8'h0c;
      3: return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  function automatic void build_line();
    int unsigned nw;
    int unsigned len;
    int unsigned r;
    logic        in_comment;
    nw = $urandom_range(0, 6);
    in_comment = 1'b0;
    for (int unsigned w = 0; w < nw && !in_comment; w++) begin
      if (w > 0 || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) put_byte(blank_char());
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 6);
          repeat (len) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
              put_byte(ChBackslash);
              put_byte(CharInW'($urandom_range(0, 255)));
            end else if (r == 1) begin
              put_byte(ChEquals);
            end else begin
              put_byte(plain_char());
            end
          end
        end
        5, 6: begin
          put_byte(ChQuote);
          len = $urandom_range(0, 6);
          repeat (len) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
              put_byte(ChBackslash);
              put_byte(CharInW'($urandom_range(0, 255)));
            end else if (r == 1) begin
              put_byte(CharInW'($urandom_range(0, 255)));
            end else if (r == 2) begin
              put_byte(ChHash);   // parse error
            end else begin
              put_byte(quoted_char());
            end
          end
          if ($urandom_range(0, 7) != 0) put_byte(ChQuote);
        end
        7: begin
          put_byte(plain_char());
          put_byte(plain_char());
          put_byte(ChEquals);
          put_byte(plain_char());
          put_byte(plain_char());
        end
        8: begin
          put_byte(ChHash);
          repeat ($urandom_range(0, 5)) put_byte(quoted_char());
          in_comment = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) put_end();
          else put_byte(CharInW'($urandom_range(0, 255)));
        end
      endcase
    end
    r = $urandom_range(0, 9);
    if (r < 7) put_byte(ChNewline);
    else if (r < 9) put_end();
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stalls, in-order compare against the predictor
  // ---------------------------------------------------------------------
  initial begin
    int unsigned gap;
    token_t      e;
    out_ch.ready = 1'b0;
    forever begin
      gap = pick_gap(snk_calm);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (token_q.size() == 0) begin
        note_fail($sformatf("unexpected result: kind %0d char %h index %0d last %b",
                            out_ch.kind, out_ch.char_out, out_ch.word_index, out_ch.last));
      end else begin
        e = token_q.pop_front();
        if (out_ch.kind != e.kind || out_ch.char_out != e.char_out ||
            out_ch.word_index != e.word_index || out_ch.last != e.last) begin
          note_fail($sformatf({"result mismatch: expected kind %0d char %h index %0d last %b,",
                               " got kind %0d char %h index %0d last %b"},
                              e.kind, e.char_out, e.word_index, e.last,
                              out_ch.kind, out_ch.char_out, out_ch.word_index, out_ch.last));
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int       n;
    int       sent;
    byte_in_t b;
    token_t   t;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgMaxWords;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = CmdChar;
    in_ch.char_in = '0;
    err_cnt       = 0;
    src_calm      = 0;
    snk_calm      = 0;
    quiet_cycles  = 0;
    ps            = PsStart;
    wcnt          = '0;
    wlen          = '0;
    lim_words     = MaxWordsRst;
    lim_len       = MaxLenRst;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset limits
    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTab[i].cmd, DirTab[i].ch, n);
      if (DirTab[i].typed) begin
        t = '0;
        if (n > 0) t = step_buf[n-1];
        if (n != DirTab[i].n ||
            (n > 0 && (t.kind != DirTab[i].kind || t.word_index != DirTab[i].idx))) begin
          note_fail($sformatf({"row %0d: expected %0d results ending kind %0d index %0d,",
                               " got %0d results ending kind %0d index %0d"},
                              i, DirTab[i].n, DirTab[i].kind, DirTab[i].idx,
                              n, t.kind, t.word_index));
        end
      end
    end

    // Random lines under several limit settings: no limits, tightest limits,
    // widest limits, then small random ones.
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CfgMaxWords, CfgDataW'($urandom_range(0, 255)) << CountW);
          write_reg(CfgMaxLen, '0);
        end
        1: begin
          write_reg(CfgMaxWords, 16'd1);
          write_reg(CfgMaxLen, 16'd1);
        end
        2: begin
          write_reg(CfgMaxWords, 16'd255);
          write_reg(CfgMaxLen, 16'hffff);
        end
        default: begin
          write_reg(CfgMaxWords, CfgDataW'($urandom_range(0, 3)));
          write_reg(CfgMaxLen, CfgDataW'($urandom_range(0, 4)));
        end
      endcase
      sent = 0;
      while (sent < 18) begin
        line_q.delete();
        build_line();
        while (line_q.size() != 0) begin
          b = line_q.pop_front();
          send_byte(b.cmd, b.ch, n);
          sent++;
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- config_line_tokenizer.f -----
sv/clt_pkg.sv
sv/clt_if.sv
sv/clt_front.sv
sv/clt_queue.sv
sv/clt_back.sv
sv/config_line_tokenizer.sv
bench/config_line_tokenizer_tb.sv
